@@ sv/jmsi_pkg.sv @@
// jmsi_pkg: word types, parse phases, status codes and marker constants
// for the JPEG marker segment indexer. No dependencies.

package jmsi_pkg;

	localparam int HEADER_BYTES_DEF = 29;
	localparam int OQ_DEPTH = 4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_file;
	} in_word_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] segment_offset;
		logic [16:0] segment_bytes;
		logic [7:0]  marker_code;
		logic        xmp_flag;
		logic [15:0] segment_number;
		logic [3:0]  status;
		logic [31:0] scan_offset;
		logic [15:0] insert_position;
		logic [32:0] rewritten_size;
		logic        last_result;
	} out_word_t;

	typedef struct packed {
		logic first;
		logic second;
	} push_t;

	typedef enum logic [12:0] {
		PH_SOI0    = 13'b0000000000001,
		PH_SOI1    = 13'b0000000000010,
		PH_MARK    = 13'b0000000000100,
		PH_FILL    = 13'b0000000001000,
		PH_LEN_HI  = 13'b0000000010000,
		PH_LEN_LO  = 13'b0000000100000,
		PH_PAYLOAD = 13'b0000001000000,
		PH_SOS_HI  = 13'b0000010000000,
		PH_SOS_LO  = 13'b0000100000000,
		PH_SOS_PAY = 13'b0001000000000,
		PH_ENTROPY = 13'b0010000000000,
		PH_TRAIL   = 13'b0100000000000,
		PH_ERR     = 13'b1000000000000
	} phase_t;

	localparam logic [3:0] ST_OK         = 4'd0;
	localparam logic [3:0] ST_NO_SOI     = 4'd1;
	localparam logic [3:0] ST_BAD_MARKER = 4'd2;
	localparam logic [3:0] ST_IN_MARKER  = 4'd3;
	localparam logic [3:0] ST_SOS_TRUNC  = 4'd4;
	localparam logic [3:0] ST_NO_EOI     = 4'd5;
	localparam logic [3:0] ST_BAD_LENGTH = 4'd6;
	localparam logic [3:0] ST_TRUNCATED  = 4'd7;
	localparam logic [3:0] ST_NO_SCAN    = 4'd8;
	localparam logic [3:0] ST_XMP_BIG    = 4'd9;

	localparam logic [7:0] MK_FF   = 8'hFF;
	localparam logic [7:0] MK_SOI  = 8'hD8;
	localparam logic [7:0] MK_EOI  = 8'hD9;
	localparam logic [7:0] MK_SOS  = 8'hDA;
	localparam logic [7:0] MK_APP0 = 8'hE0;
	localparam logic [7:0] MK_APP1 = 8'hE1;
	localparam logic [7:0] MK_RST0 = 8'hD0;
	localparam logic [7:0] MK_RST7 = 8'hD7;
	localparam logic [7:0] MK_STUF = 8'h00;

	localparam logic [32:0] MAX33 = 33'h1FFFFFFFF;
	localparam logic [15:0] MAX16 = 16'hFFFF;

	// XMP namespace header, zero padded to 32 bytes
	localparam logic [7:0] NS_HEADER [32] = '{
		8'h68, 8'h74, 8'h74, 8'h70, 8'h3A, 8'h2F, 8'h2F, 8'h6E,
		8'h73, 8'h2E, 8'h61, 8'h64, 8'h6F, 8'h62, 8'h65, 8'h2E,
		8'h63, 8'h6F, 8'h6D, 8'h2F, 8'h78, 8'h61, 8'h70, 8'h2F,
		8'h31, 8'h2E, 8'h30, 8'h2F, 8'h00, 8'h00, 8'h00, 8'h00
	};

endpackage

@@ sv/jmsi_parser.sv @@
// jmsi_parser: marker segment walk, entropy scan and result formation, one byte a step.
// Depends on jmsi_pkg.

module jmsi_parser #(
	parameter int HEADER_BYTES = jmsi_pkg::HEADER_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  jmsi_pkg::in_word_t  word,
	input  logic [15:0]         xmp_len,
	output jmsi_pkg::push_t     push,
	output jmsi_pkg::out_word_t res0,
	output jmsi_pkg::out_word_t res1
);

	localparam int IDX_W = $clog2(HEADER_BYTES + 1);
	localparam logic [16:0] HB17 = 17'(HEADER_BYTES);

	jmsi_pkg::phase_t phase_q, phase_d;
	logic [31:0] pos_q, pos_d;
	logic [31:0] start_q, start_d;
	logic [7:0]  run_q, run_d;
	logic [7:0]  marker_q, marker_d;
	logic [15:0] len_q, len_d;
	logic [15:0] left_q, left_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic        match_q, match_d;
	logic [15:0] seen_q, seen_d;
	logic [15:0] insert_q, insert_d;
	logic [32:0] kept_q, kept_d;
	logic [31:0] scan_q, scan_d;
	logic        prev_ff_q, prev_ff_d;
	logic [3:0]  err_q, err_d;

	logic [7:0]  b;
	logic        eof;
	logic        finish;
	logic [3:0]  fail_code;
	logic [16:0] seg_bytes;
	logic        xmp;
	logic [33:0] kept_sum;
	logic [3:0]  status;
	logic        xmp_big;
	logic [16:0] xmp_extra;
	logic [31:0] scan_len;
	logic [34:0] size_sum;
	logic [32:0] size;
	jmsi_pkg::out_word_t rec, summ;

	assign b   = word.data_byte;
	assign eof = word.end_of_file;
	assign xmp_big = (xmp_len != 16'd0) && ((17'd2 + HB17 + {1'b0, xmp_len}) > 17'h0FFFF);
	assign xmp_extra = (xmp_len != 16'd0) ? (17'd4 + HB17 + {1'b0, xmp_len}) : 17'd0;

	always_comb begin
		phase_d   = phase_q;
		pos_d     = pos_q + 32'd1;
		start_d   = start_q;
		run_d     = run_q;
		marker_d  = marker_q;
		len_d     = len_q;
		left_d    = left_q;
		idx_d     = idx_q;
		match_d   = match_q;
		seen_d    = seen_q;
		insert_d  = insert_q;
		kept_d    = kept_q;
		scan_d    = scan_q;
		prev_ff_d = prev_ff_q;
		err_d     = err_q;
		finish    = 1'b0;
		fail_code = jmsi_pkg::ST_OK;
		seg_bytes = 17'd0;
		xmp       = 1'b0;
		kept_sum  = 34'd0;

		unique case (phase_q)
			jmsi_pkg::PH_SOI0: begin
				if (b == jmsi_pkg::MK_FF) phase_d = jmsi_pkg::PH_SOI1;
				else fail_code = jmsi_pkg::ST_NO_SOI;
			end
			jmsi_pkg::PH_SOI1: begin
				if (b == jmsi_pkg::MK_SOI) phase_d = jmsi_pkg::PH_MARK;
				else fail_code = jmsi_pkg::ST_NO_SOI;
			end
			jmsi_pkg::PH_MARK: begin
				if (b == jmsi_pkg::MK_FF) begin
					start_d = pos_q;
					run_d   = 8'd1;
					phase_d = jmsi_pkg::PH_FILL;
				end else begin
					fail_code = jmsi_pkg::ST_BAD_MARKER;
				end
			end
			jmsi_pkg::PH_FILL: begin
				if (b == jmsi_pkg::MK_FF) begin
					if (run_q != jmsi_pkg::MK_FF) run_d = run_q + 8'd1;
				end else if (b == jmsi_pkg::MK_STUF ||
						(b >= jmsi_pkg::MK_RST0 && b <= jmsi_pkg::MK_RST7)) begin
					phase_d = jmsi_pkg::PH_MARK;
				end else if (b == jmsi_pkg::MK_EOI) begin
					scan_d  = start_q;
					phase_d = jmsi_pkg::PH_TRAIL;
				end else if (b == jmsi_pkg::MK_SOS) begin
					scan_d   = start_q;
					marker_d = b;
					phase_d  = jmsi_pkg::PH_SOS_HI;
				end else begin
					marker_d = b;
					phase_d  = jmsi_pkg::PH_LEN_HI;
				end
			end
			jmsi_pkg::PH_LEN_HI: begin
				len_d   = {b, 8'h00};
				phase_d = jmsi_pkg::PH_LEN_LO;
			end
			jmsi_pkg::PH_SOS_HI: begin
				len_d   = {b, 8'h00};
				phase_d = jmsi_pkg::PH_SOS_LO;
			end
			jmsi_pkg::PH_LEN_LO: begin
				len_d = {len_q[15:8], b};
				if (len_d < 16'd2) begin
					fail_code = jmsi_pkg::ST_BAD_LENGTH;
				end else begin
					left_d  = len_d - 16'd2;
					idx_d   = '0;
					match_d = 1'b1;
					if (left_d == 16'd0) finish = 1'b1;
					else phase_d = jmsi_pkg::PH_PAYLOAD;
				end
			end
			jmsi_pkg::PH_PAYLOAD: begin
				if (32'(idx_q) < 32'(HEADER_BYTES)) begin
					if (b != jmsi_pkg::NS_HEADER[5'(idx_q)]) match_d = 1'b0;
					idx_d = idx_q + 1'b1;
				end
				left_d = left_q - 16'd1;
				if (left_d == 16'd0) finish = 1'b1;
			end
			jmsi_pkg::PH_SOS_LO: begin
				len_d = {len_q[15:8], b};
				if (len_d < 16'd2) begin
					fail_code = jmsi_pkg::ST_SOS_TRUNC;
				end else begin
					left_d    = len_d - 16'd2;
					prev_ff_d = 1'b0;
					phase_d   = (left_d == 16'd0) ? jmsi_pkg::PH_ENTROPY : jmsi_pkg::PH_SOS_PAY;
				end
			end
			jmsi_pkg::PH_SOS_PAY: begin
				left_d = left_q - 16'd1;
				if (left_d == 16'd0) phase_d = jmsi_pkg::PH_ENTROPY;
			end
			jmsi_pkg::PH_ENTROPY: begin
				if (prev_ff_q && b == jmsi_pkg::MK_EOI) begin
					prev_ff_d = 1'b0;
					phase_d   = jmsi_pkg::PH_TRAIL;
				end else begin
					prev_ff_d = (b == jmsi_pkg::MK_FF);
				end
			end
			jmsi_pkg::PH_TRAIL: begin
			end
			default: phase_d = jmsi_pkg::PH_ERR;
		endcase

		if (fail_code != jmsi_pkg::ST_OK) begin
			if (err_q == jmsi_pkg::ST_OK) err_d = fail_code;
			phase_d = jmsi_pkg::PH_ERR;
		end

		if (finish) begin
			seg_bytes = {9'd0, run_q} + 17'd1 + {1'b0, len_d};
			xmp = (marker_q == jmsi_pkg::MK_APP1) && ({1'b0, len_d} >= 17'd2 + HB17) && match_d;
			seen_d = (seen_q != jmsi_pkg::MAX16) ? seen_q + 16'd1 : seen_q;
			if (marker_q == jmsi_pkg::MK_APP0 || (marker_q == jmsi_pkg::MK_APP1 && !xmp))
				insert_d = seen_d;
			if (!xmp) begin
				kept_sum = {1'b0, kept_q} + {17'd0, seg_bytes};
				kept_d = (kept_sum > {1'b0, jmsi_pkg::MAX33}) ? jmsi_pkg::MAX33 : kept_sum[32:0];
			end
			phase_d = jmsi_pkg::PH_MARK;
		end
	end

	always_comb begin
		if (err_d != jmsi_pkg::ST_OK) begin
			status = err_d;
		end else begin
			unique case (phase_d)
				jmsi_pkg::PH_SOI0, jmsi_pkg::PH_SOI1: status = jmsi_pkg::ST_NO_SOI;
				jmsi_pkg::PH_MARK:                    status = jmsi_pkg::ST_NO_SCAN;
				jmsi_pkg::PH_FILL:                    status = jmsi_pkg::ST_IN_MARKER;
				jmsi_pkg::PH_LEN_HI, jmsi_pkg::PH_LEN_LO: status = jmsi_pkg::ST_BAD_LENGTH;
				jmsi_pkg::PH_PAYLOAD:                 status = jmsi_pkg::ST_TRUNCATED;
				jmsi_pkg::PH_SOS_HI, jmsi_pkg::PH_SOS_LO,
				jmsi_pkg::PH_SOS_PAY:                 status = jmsi_pkg::ST_SOS_TRUNC;
				jmsi_pkg::PH_ENTROPY:                 status = jmsi_pkg::ST_NO_EOI;
				jmsi_pkg::PH_TRAIL: status = xmp_big ? jmsi_pkg::ST_XMP_BIG : jmsi_pkg::ST_OK;
				default:                              status = jmsi_pkg::ST_BAD_MARKER;
			endcase
		end
	end

	// a clean end never closes a segment on the same byte, so the kept total is settled
	assign scan_len = pos_q + 32'd1 - scan_d;
	assign size_sum = 35'd2 + {2'b00, kept_q} + {3'b000, scan_len} + {18'd0, xmp_extra};
	assign size = (status != jmsi_pkg::ST_OK) ? 33'd0 :
		(size_sum > {2'b00, jmsi_pkg::MAX33}) ? jmsi_pkg::MAX33 : size_sum[32:0];

	always_comb begin
		rec = '0;
		rec.kind           = 1'b0;
		rec.segment_offset = start_q;
		rec.segment_bytes  = seg_bytes;
		rec.marker_code    = marker_q;
		rec.xmp_flag       = xmp;
		rec.segment_number = seen_q;
		rec.last_result    = !eof;

		summ = '0;
		summ.kind            = 1'b1;
		summ.status          = status;
		summ.scan_offset     = scan_d;
		summ.insert_position = insert_d;
		summ.rewritten_size  = size;
		summ.last_result     = 1'b1;
	end

	assign push.first  = step && (finish || eof);
	assign push.second = step && finish && eof;
	assign res0 = finish ? rec : summ;
	assign res1 = summ;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= jmsi_pkg::PH_SOI0;
			pos_q     <= '0;
			start_q   <= '0;
			run_q     <= '0;
			marker_q  <= '0;
			len_q     <= '0;
			left_q    <= '0;
			idx_q     <= '0;
			match_q   <= 1'b1;
			seen_q    <= '0;
			insert_q  <= '0;
			kept_q    <= '0;
			scan_q    <= '0;
			prev_ff_q <= 1'b0;
			err_q     <= '0;
		end else if (step) begin
			if (eof) begin
				phase_q   <= jmsi_pkg::PH_SOI0;
				pos_q     <= '0;
				start_q   <= '0;
				run_q     <= '0;
				marker_q  <= '0;
				len_q     <= '0;
				left_q    <= '0;
				idx_q     <= '0;
				match_q   <= 1'b1;
				seen_q    <= '0;
				insert_q  <= '0;
				kept_q    <= '0;
				scan_q    <= '0;
				prev_ff_q <= 1'b0;
				err_q     <= '0;
			end else begin
				phase_q   <= phase_d;
				pos_q     <= pos_d;
				start_q   <= start_d;
				run_q     <= run_d;
				marker_q  <= marker_d;
				len_q     <= len_d;
				left_q    <= left_d;
				idx_q     <= idx_d;
				match_q   <= match_d;
				seen_q    <= seen_d;
				insert_q  <= insert_d;
				kept_q    <= kept_d;
				scan_q    <= scan_d;
				prev_ff_q <= prev_ff_d;
				err_q     <= err_d;
			end
		end
	end

endmodule

@@ sv/jmsi_out_queue.sv @@
// jmsi_out_queue: small result queue taking up to two words a cycle.
// Depends on jmsi_pkg.

module jmsi_out_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  jmsi_pkg::push_t     push,
	input  jmsi_pkg::out_word_t w0,
	input  jmsi_pkg::out_word_t w1,
	output logic                room,
	output logic                out_valid,
	input  logic                out_ready,
	output jmsi_pkg::out_word_t out_data
);

	localparam int PW = $clog2(jmsi_pkg::OQ_DEPTH);
	localparam int CW = $clog2(jmsi_pkg::OQ_DEPTH + 1);

	jmsi_pkg::out_word_t mem_q [jmsi_pkg::OQ_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          pop;
	logic [CW-1:0] n_push;

	assign pop       = out_valid && out_ready;
	assign out_valid = (cnt_q != '0);
	assign out_data  = mem_q[rd_q];
	assign room      = ((cnt_q - CW'(pop)) <= CW'(jmsi_pkg::OQ_DEPTH - 2));
	assign n_push    = CW'(push.first) + CW'(push.second);

	always_ff @(posedge clk) begin
		if (push.first) mem_q[wr_q] <= w0;
		if (push.second) mem_q[wr_q + PW'(1)] <= w1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PW'(n_push);
			rd_q  <= rd_q + PW'(pop);
			cnt_q <= cnt_q + n_push - CW'(pop);
		end
	end

endmodule

@@ sv/jpeg_marker_segment_indexer_core.sv @@
// jpeg_marker_segment_indexer_core: top level; input register, config register,
// parser and result queue. Depends on jmsi_pkg, jmsi_parser, jmsi_out_queue.
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid / in_ready       in_data   (jmsi_pkg::in_word_t)
//   out      source     out_valid / out_ready     out_data  (jmsi_pkg::out_word_t)
//   cfg      sink       cfg_valid / cfg_ready     cfg_data  (16-bit XMP payload length)
//
// One byte per cycle while the queue has room; each byte is parsed from the input register.
// Each byte yields zero, one or two words into a four-word result queue.
// The input stalls only when the queue has fewer than two free slots.
// Reset clears the parse state and the XMP payload length; cfg_ready is always high.

module jpeg_marker_segment_indexer_core #(
	parameter int HEADER_BYTES = jmsi_pkg::HEADER_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  jmsi_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output jmsi_pkg::out_word_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [15:0]         cfg_data
);

	logic                valid_s1;
	jmsi_pkg::in_word_t  word_s1;
	logic [15:0]         xmp_len_q;
	logic                room;
	logic                step;
	jmsi_pkg::push_t     push;
	jmsi_pkg::out_word_t res0, res1;

	assign cfg_ready = 1'b1;
	assign step      = valid_s1 && room;
	assign in_ready  = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			xmp_len_q <= '0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (cfg_valid && cfg_ready) xmp_len_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) word_s1 <= in_data;
	end

	jmsi_parser #(
		.HEADER_BYTES(HEADER_BYTES)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.word    (word_s1),
		.xmp_len (xmp_len_q),
		.push    (push),
		.res0    (res0),
		.res1    (res1)
	);

	jmsi_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.w0        (res0),
		.w1        (res1),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && !room)
		else $error("input stalled without a pending byte blocked by the queue");

	a_record_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.kind |-> out_data.status == jmsi_pkg::ST_OK &&
			out_data.rewritten_size == 33'd0)
		else $error("segment record carries summary fields");

	a_summary_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind |-> out_data.last_result)
		else $error("summary not marked last");

	a_two_words: assert property (@(posedge clk) disable iff (!arst_n)
		push.second |-> push.first && step)
		else $error("second word pushed alone");

endmodule

@@ dv/testbench.sv @@
// testbench: self-checking bench for jpeg_marker_segment_indexer_core. A scoreboard class
// predicts records and summaries per accepted byte from JPEG-like files, directed and random.
// Depends on jmsi_pkg and jpeg_marker_segment_indexer_core.

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import jmsi_pkg::*;

	localparam int HB = HEADER_BYTES_DEF;
	localparam int PERIOD = 10;
	localparam int LIMIT = 1000000;
	localparam logic [7:0] MK_DQT = 8'hDB;

	class jmsi_scoreboard;
		logic [15:0] xmp_len;
		phase_t      ph;
		logic [31:0] pos, seg_start, scan_start;
		logic [7:0]  run_len, marker;
		logic [15:0] seg_len, left, seg_count, insert_after;
		int          hdr_idx;
		bit          hdr_ok, prev_ff, eoi_seen;
		logic [3:0]  err;
		longint unsigned kept;
		out_word_t   step_words[$];
		out_word_t   expected_words[$];
		int          mismatches;

		function new();
			xmp_len = '0;
			mismatches = 0;
			restart();
		endfunction

		function void restart();
			ph = PH_SOI0;
			pos = '0;
			seg_start = '0;
			scan_start = '0;
			run_len = '0;
			marker = '0;
			seg_len = '0;
			left = '0;
			seg_count = '0;
			insert_after = '0;
			hdr_idx = 0;
			hdr_ok = 1'b1;
			prev_ff = 1'b0;
			eoi_seen = 1'b0;
			err = ST_OK;
			kept = 0;
		endfunction

		function void latch_error(logic [3:0] code);
			if (err == ST_OK)
				err = code;
			ph = PH_ERR;
		endfunction

		function void close_segment();
			out_word_t   w;
			logic [16:0] total;
			bit          is_xmp;
			total = 17'(run_len) + 17'd1 + 17'(seg_len);
			is_xmp = marker == MK_APP1 && int'(seg_len) >= 2 + HB && hdr_ok;
			w = '0;
			w.segment_offset = seg_start;
			w.segment_bytes = total;
			w.marker_code = marker;
			w.xmp_flag = is_xmp;
			w.segment_number = seg_count;
			step_words.insert(step_words.size(), w);
			if (marker == MK_APP0 || (marker == MK_APP1 && !is_xmp))
				insert_after = (seg_count == MAX16) ? MAX16 : seg_count + 16'd1;
			if (seg_count != MAX16)
				seg_count++;
			if (!is_xmp) begin
				kept += total;
				if (kept > MAX33)
					kept = MAX33;
			end
			ph = PH_MARK;
		endfunction

		function logic [3:0] end_status();
			if (err != ST_OK)
				return err;
			case (ph)
				PH_SOI0, PH_SOI1: return ST_NO_SOI;
				PH_MARK: return ST_NO_SCAN;
				PH_FILL: return ST_IN_MARKER;
				PH_LEN_HI, PH_LEN_LO: return ST_BAD_LENGTH;
				PH_PAYLOAD: return ST_TRUNCATED;
				PH_SOS_HI, PH_SOS_LO, PH_SOS_PAY: return ST_SOS_TRUNC;
				PH_ENTROPY: return ST_NO_EOI;
				PH_TRAIL: ;
				default: return ST_BAD_MARKER;
			endcase
			if (xmp_len != 0 && 2 + HB + int'(xmp_len) > 'hFFFF)
				return ST_XMP_BIG;
			return ST_OK;
		endfunction

		function void note_byte(in_word_t w);
			logic [7:0]  b;
			logic [31:0] here, scan_bytes;
			out_word_t   s;
			longint unsigned size;
			b = w.data_byte;
			here = pos;
			step_words.delete();
			case (ph)
				PH_SOI0: begin
					if (b == MK_FF) ph = PH_SOI1;
					else latch_error(ST_NO_SOI);
				end
				PH_SOI1: begin
					if (b == MK_SOI) ph = PH_MARK;
					else latch_error(ST_NO_SOI);
				end
				PH_MARK: begin
					if (b == MK_FF) begin
						seg_start = here;
						run_len = 8'd1;
						ph = PH_FILL;
					end else
						latch_error(ST_BAD_MARKER);
				end
				PH_FILL: begin
					if (b == MK_FF) begin
						if (run_len != 8'hFF)
							run_len++;
					end else if (b == MK_STUF || (b >= MK_RST0 && b <= MK_RST7)) begin
						ph = PH_MARK;
					end else if (b == MK_EOI) begin
						scan_start = seg_start;
						eoi_seen = 1'b1;
						ph = PH_TRAIL;
					end else if (b == MK_SOS) begin
						scan_start = seg_start;
						marker = b;
						ph = PH_SOS_HI;
					end else begin
						marker = b;
						ph = PH_LEN_HI;
					end
				end
				PH_LEN_HI, PH_SOS_HI: begin
					seg_len = {b, 8'h00};
					ph = (ph == PH_LEN_HI) ? PH_LEN_LO : PH_SOS_LO;
				end
				PH_LEN_LO: begin
					seg_len[7:0] = b;
					if (seg_len < 2) begin
						latch_error(ST_BAD_LENGTH);
					end else begin
						left = seg_len - 16'd2;
						hdr_idx = 0;
						hdr_ok = 1'b1;
						if (left == 0) close_segment();
						else ph = PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					if (hdr_idx < HB) begin
						if (b != NS_HEADER[hdr_idx])
							hdr_ok = 1'b0;
						hdr_idx++;
					end
					left--;
					if (left == 0)
						close_segment();
				end
				PH_SOS_LO: begin
					seg_len[7:0] = b;
					if (seg_len < 2) begin
						latch_error(ST_SOS_TRUNC);
					end else begin
						left = seg_len - 16'd2;
						prev_ff = 1'b0;
						ph = (left == 0) ? PH_ENTROPY : PH_SOS_PAY;
					end
				end
				PH_SOS_PAY: begin
					left--;
					if (left == 0)
						ph = PH_ENTROPY;
				end
				PH_ENTROPY: begin
					if (prev_ff && b == MK_EOI) begin
						eoi_seen = 1'b1;
						prev_ff = 1'b0;
						ph = PH_TRAIL;
					end else
						prev_ff = (b == MK_FF);
				end
				PH_TRAIL: ;
				default: ph = PH_ERR;
			endcase

			if (w.end_of_file) begin
				s = '0;
				s.kind = 1'b1;
				s.status = end_status();
				s.scan_offset = scan_start;
				s.insert_position = insert_after;
				if (s.status == ST_OK) begin
					scan_bytes = here + 32'd1 - scan_start;
					size = 64'd2 + kept + 64'(scan_bytes);
					if (xmp_len != 0)
						size += 64'(4 + HB) + 64'(xmp_len);
					if (size > MAX33)
						size = MAX33;
					s.rewritten_size = size[32:0];
				end
				step_words.insert(step_words.size(), s);
			end
			if (step_words.size() != 0)
				step_words[step_words.size() - 1].last_result = 1'b1;
			foreach (step_words[i])
				expected_words.insert(expected_words.size(), step_words[i]);

			pos = here + 32'd1;
			if (w.end_of_file)
				restart();
		endfunction

		function void cmp_field(string name, logic [32:0] want, logic [32:0] got);
			if (want !== got) begin
				mismatches++;
				if (mismatches <= 40)
					$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			end
		endfunction

		function void check_word(out_word_t got);
			out_word_t want;
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 40)
					$display("%0t: unexpected word expected none actual %h", $time, got);
				return;
			end
			want = expected_words.pop_front();
			cmp_field("kind", want.kind, got.kind);
			cmp_field("segment_offset", want.segment_offset, got.segment_offset);
			cmp_field("segment_bytes", want.segment_bytes, got.segment_bytes);
			cmp_field("marker_code", want.marker_code, got.marker_code);
			cmp_field("xmp_flag", want.xmp_flag, got.xmp_flag);
			cmp_field("segment_number", want.segment_number, got.segment_number);
			cmp_field("status", want.status, got.status);
			cmp_field("scan_offset", want.scan_offset, got.scan_offset);
			cmp_field("insert_position", want.insert_position, got.insert_position);
			cmp_field("rewritten_size", want.rewritten_size, got.rewritten_size);
			cmp_field("last_result", want.last_result, got.last_result);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_word_t    in_data;
	logic        out_valid;
	logic        out_ready;
	out_word_t   out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;

	jmsi_scoreboard sb;
	logic [7:0]     file_bytes[$];
	int             phase_bytes;
	int             cycles;
	bit             no_idle;
	bit             hold_req;

	jpeg_marker_segment_indexer_core #(.HEADER_BYTES(HB)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial clk = 1'b0;
	always #(PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [15:0] short_len();
		if ($urandom_range(0, 3) == 0)
			return 16'd2;
		return 16'($urandom_range(3, 10));
	endfunction

	function automatic logic [7:0] other_code();
		logic [7:0] c;
		c = 8'($urandom_range(1, 254));
		if (c == MK_EOI || c == MK_SOS || (c >= MK_RST0 && c <= MK_RST7))
			c = MK_DQT;
		return c;
	endfunction

	function automatic void put_byte(logic [7:0] v);
		file_bytes.insert(file_bytes.size(), v);
	endfunction

	function automatic void add_segment(logic [7:0] code, logic [15:0] len, bit ns_hdr,
			int fills, int spoil);
		int body;
		repeat (fills) put_byte(MK_FF);
		put_byte(code);
		put_byte(len[15:8]);
		put_byte(len[7:0]);
		body = (len < 2) ? 0 : int'(len) - 2;
		for (int i = 0; i < body; i++) begin
			if (ns_hdr && i < HB)
				put_byte((i == spoil) ? NS_HEADER[i] ^ 8'h01 : NS_HEADER[i]);
			else
				put_byte(8'($urandom_range(0, 255)));
		end
	endfunction

	function automatic void add_scan(int head_len, int n_data, bit with_eoi);
		put_byte(MK_FF);
		put_byte(MK_SOS);
		put_byte(8'(head_len >> 8));
		put_byte(8'(head_len));
		repeat (head_len - 2) put_byte(8'($urandom_range(0, 255)));
		repeat (n_data) begin
			case ($urandom_range(0, 9))
				0: begin
					put_byte(MK_FF);
					put_byte(MK_STUF);
				end
				1: begin
					put_byte(MK_FF);
					put_byte(MK_RST0 + 8'($urandom_range(0, 7)));
				end
				2: begin
					put_byte(MK_FF);
					put_byte(MK_FF);
				end
				default: put_byte(8'($urandom_range(0, 255)));
			endcase
		end
		if (with_eoi) begin
			put_byte(MK_FF);
			put_byte(MK_EOI);
		end
	endfunction

	function automatic void build_random_file(bit well_formed);
		int r, fills;
		file_bytes.delete();
		r = $urandom_range(0, 99);
		if (!well_formed && r < 8) begin
			repeat ($urandom_range(1, 10)) put_byte(8'($urandom_range(0, 255)));
			return;
		end
		put_byte(MK_FF);
		put_byte((!well_formed && r < 11) ? 8'($urandom_range(0, 255)) : MK_SOI);
		repeat ($urandom_range(0, 3)) begin
			if ($urandom_range(0, 9) == 0) begin
				put_byte(MK_FF);
				put_byte($urandom_range(0, 1) ? MK_STUF
					: MK_RST0 + 8'($urandom_range(0, 7)));
			end
			fills = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 4) : 1;
			case ($urandom_range(0, 5))
				0: add_segment(MK_APP0, short_len(), 1'b0, fills, -1);
				1: add_segment(MK_APP1, 16'($urandom_range(24, 44)), 1'b1, fills,
					($urandom_range(0, 3) == 0) ? $urandom_range(0, HB - 1) : -1);
				2: add_segment(MK_APP1, short_len(), 1'b0, fills, -1);
				3: add_segment(other_code(), (!well_formed && $urandom_range(0, 4) == 0)
					? 16'($urandom_range(0, 1)) : short_len(), 1'b0, fills, -1);
				default: add_segment(other_code(), short_len(), 1'b0, fills, -1);
			endcase
		end
		r = $urandom_range(0, 99);
		if (!well_formed && r < 8) begin
			// truncated segment with a full-range length
			put_byte(MK_FF);
			put_byte(other_code());
			put_byte(8'($urandom_range(0, 255)));
			put_byte(8'($urandom_range(0, 255)));
			repeat ($urandom_range(0, 4)) put_byte(8'($urandom_range(0, 255)));
		end else if (r < 20) begin
			put_byte(MK_FF);
			put_byte(MK_EOI);
		end else begin
			add_scan($urandom_range(2, 12), $urandom_range(0, 14), $urandom_range(0, 19) != 0);
		end
		repeat ($urandom_range(0, 2)) put_byte(8'($urandom_range(0, 255)));
		if (!well_formed) begin
			r = $urandom_range(0, 99);
			if (r < 20)
				file_bytes = file_bytes[0:$urandom_range(0, file_bytes.size() - 1)];
			else if (r < 28)
				file_bytes[$urandom_range(0, file_bytes.size() - 1)] = 8'($urandom_range(0, 255));
		end
	endfunction

	task automatic send_byte(in_word_t w);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
		sb.note_byte(w);
	endtask

	task automatic send_file();
		in_word_t w;
		foreach (file_bytes[i]) begin
			w.data_byte = file_bytes[i];
			w.end_of_file = (i == file_bytes.size() - 1);
			send_byte(w);
			phase_bytes++;
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.expected_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_xmp_len(logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.xmp_len = value;
	endtask

	// result side: random stalls plus one long hold-off on request
	initial begin
		int stall_left, hold_left;
		stall_left = 0;
		hold_left = 0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_word(out_data);
			if (hold_req) begin
				hold_left = 400;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!no_idle && $urandom_range(0, 99) < 20)
					stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50)
						: $urandom_range(1, 3);
			end
		end
	end

	initial begin
		logic [15:0] xmp_lens[6];
		sb = new();
		cycles = 0;
		no_idle = 1'b0;
		hold_req = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed files, register at its reset value
		file_bytes = '{8'h00};
		send_file();
		file_bytes = '{MK_FF, MK_SOI};
		send_file();
		file_bytes = '{MK_FF, MK_SOI, MK_FF, MK_FF};
		send_file();
		file_bytes = '{MK_FF, MK_SOI, MK_FF, MK_APP0, 8'h00};
		send_file();
		file_bytes = '{MK_FF, MK_SOI, MK_FF, MK_APP0, 8'h00, 8'h01, MK_FF, MK_SOI};
		send_file();
		file_bytes = '{MK_FF, MK_SOI, 8'h12};
		send_file();
		file_bytes = '{MK_FF, MK_SOI, MK_FF, MK_STUF, MK_FF, MK_RST0 + 8'd3, MK_FF, MK_EOI, 8'h55};
		send_file();
		file_bytes = '{MK_FF, MK_SOI, MK_FF, MK_SOS, 8'h00, 8'h03};
		send_file();
		file_bytes = '{MK_FF, MK_SOI, MK_FF, MK_SOS, 8'h00, 8'h01};
		send_file();
		file_bytes = '{MK_FF, MK_SOI, MK_FF, MK_SOS, 8'h00, 8'h02, 8'hAB};
		send_file();
		file_bytes = '{MK_FF, MK_SOI, MK_FF, MK_DQT, 8'h00, 8'h05, 8'h11};
		send_file();
		// largest segment length, cut short in the payload
		file_bytes = '{MK_FF, MK_SOI, MK_FF, MK_DQT, 8'hFF, 8'hFF, 8'h11};
		send_file();
		file_bytes = '{MK_FF, MK_SOI};
		add_segment(MK_APP1, 16'(2 + HB), 1'b1, 1, -1);
		add_segment(MK_APP0, 16'd4, 1'b0, 2, -1);
		add_segment(MK_APP1, 16'd6, 1'b0, 1, -1);
		add_scan(3, 6, 1'b1);
		put_byte(8'h7E);
		send_file();
		wait_idle();

		xmp_lens = '{16'hFFFF, 16'hFFE0, 16'h0000, 16'hFFE1, 16'($urandom_range(1, 65535)),
			16'h0001};
		for (int p = 0; p < 6; p++) begin
			no_idle = (p == 2);
			write_xmp_len(xmp_lens[p]);
			if (p == 3)
				hold_req = 1'b1;
			phase_bytes = 0;
			while (phase_bytes < ((p == 3) ? 90 : 24)) begin
				build_random_file(p == 3);
				send_file();
			end
			wait_idle();
		end

		// fill run longer than the run count can hold
		no_idle = 1'b1;
		write_xmp_len(16'h0100);
		file_bytes = '{MK_FF, MK_SOI};
		add_segment(MK_APP1, 16'(2 + HB), 1'b1, 260, -1);
		add_scan(2, 4, 1'b1);
		send_file();
		wait_idle();
		repeat (16) @(posedge clk);

		if (sb.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

@@ sim.f @@
sv/jmsi_pkg.sv
sv/jmsi_parser.sv
sv/jmsi_out_queue.sv
sv/jpeg_marker_segment_indexer_core.sv
dv/testbench.sv
